// ----- src/multiplexed_servo_pulse_sequencer_defines.svh -----
// Assertion macros shared by the servo sequencer checker.
`ifndef MULTIPLEXED_SERVO_PULSE_SEQUENCER_DEFINES_SVH
`define MULTIPLEXED_SERVO_PULSE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSPS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("servo sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSPS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("servo sequencer check failed");

`endif

// ----- src/msps_pkg.sv -----
// Types and constants of the multiplexed servo pulse sequencer.
package msps_pkg;

	localparam int NUM_CHANNELS_DEF = 8;

	localparam logic [11:0] MIN_PULSE_RST  = 12'd544;
	localparam logic [11:0] MAX_PULSE_RST  = 12'd2400;
	localparam logic [15:0] SLOT_LENGTH_RST = 16'd2500;

	localparam logic [1:0] CFG_MIN_PULSE   = 2'd0;
	localparam logic [1:0] CFG_MAX_PULSE   = 2'd1;
	localparam logic [1:0] CFG_SLOT_LENGTH = 2'd2;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_SET      = 2'd1,
		OP_INCREASE = 2'd2,
		OP_DECREASE = 2'd3
	} op_t;

	typedef struct packed {
		logic [11:0] min_pulse_us;
		logic [11:0] max_pulse_us;
		logic [15:0] slot_length_us;
	} cfg_t;

	typedef struct packed {
		op_t         operation;
		logic [2:0]  channel;
		logic [11:0] amount_us;
	} item_t;

	typedef struct packed {
		logic [11:0] channel_width_us;
		logic        command_ignored;
		logic [2:0]  active_channel;
		logic [7:0]  pin_levels;
	} result_t;

endpackage

// ----- src/msps_cfg_regs.sv -----
// Configuration register bank of the servo sequencer.
module msps_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output msps_pkg::cfg_t      cfg
);

	msps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse_us   <= msps_pkg::MIN_PULSE_RST;
			cfg_q.max_pulse_us   <= msps_pkg::MAX_PULSE_RST;
			cfg_q.slot_length_us <= msps_pkg::SLOT_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				msps_pkg::CFG_MIN_PULSE:   cfg_q.min_pulse_us   <= cfg_data[11:0];
				msps_pkg::CFG_MAX_PULSE:   cfg_q.max_pulse_us   <= cfg_data[11:0];
				msps_pkg::CFG_SLOT_LENGTH: cfg_q.slot_length_us <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/msps_core.sv -----
// Servo state and the single-pass update for one item.
module msps_core #(
	parameter int NumChannels = msps_pkg::NUM_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  msps_pkg::item_t     item,
	input  msps_pkg::cfg_t      cfg,
	output msps_pkg::result_t   result
);

	localparam int ChW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

	// The widths live in a ring that rotates at each slot end, so entry 0
	// always belongs to the channel whose slot is running.
	logic [11:0]    ring_q [NumChannels];
	logic [11:0]    ring_d [NumChannels];
	logic [ChW-1:0] slot_q, slot_d;
	logic [15:0]    cnt_q, cnt_d;
	logic [11:0]    latched_q, latched_d;

	logic           in_range;
	logic [ChW-1:0] chi;
	logic [ChW:0]   rel_pos;
	logic [ChW-1:0] idx;
	logic [11:0]    w_cur;
	logic [11:0]    w_set;
	logic [12:0]    w_sum;
	logic [11:0]    w_new;
	logic           ignored;
	logic [16:0]    cnt_inc;
	logic           slot_end;

	always_comb begin
		in_range = {2'b00, item.channel} < 5'(NumChannels);
		chi      = ChW'(item.channel);
		rel_pos  = {1'b0, chi} - {1'b0, slot_q};
		if (rel_pos[ChW]) begin
			rel_pos = rel_pos + (ChW + 1)'(NumChannels);
		end
		idx   = rel_pos[ChW-1:0];
		w_cur = ring_q[idx];

		w_set = (item.amount_us > cfg.max_pulse_us) ? cfg.max_pulse_us : item.amount_us;
		if (w_set < cfg.min_pulse_us) begin
			w_set = cfg.min_pulse_us;
		end
		w_sum = {1'b0, w_cur} + {1'b0, item.amount_us};

		w_new   = w_cur;
		ignored = 1'b0;
		case (item.operation)
			msps_pkg::OP_SET: begin
				w_new = w_set;
			end
			msps_pkg::OP_INCREASE: begin
				if (w_sum > {1'b0, cfg.max_pulse_us}) begin
					ignored = 1'b1;
				end else begin
					w_new = w_sum[11:0];
				end
			end
			msps_pkg::OP_DECREASE: begin
				if (w_cur < item.amount_us || (w_cur - item.amount_us) < cfg.min_pulse_us) begin
					ignored = 1'b1;
				end else begin
					w_new = w_cur - item.amount_us;
				end
			end
			default: ;
		endcase
		if (!in_range) begin
			ignored = 1'b0;
		end

		cnt_inc   = {1'b0, cnt_q} + 17'd1;
		slot_end  = cnt_inc >= {1'b0, cfg.slot_length_us};
		ring_d    = ring_q;
		slot_d    = slot_q;
		cnt_d     = cnt_q;
		latched_d = latched_q;
		if (item.operation == msps_pkg::OP_TICK) begin
			if (cnt_q == 16'd0) begin
				latched_d = ring_q[0];
			end
			if (slot_end) begin
				cnt_d  = 16'd0;
				slot_d = (slot_q == ChW'(NumChannels - 1)) ? '0 : slot_q + ChW'(1);
				for (int i = 0; i < NumChannels; i++) begin
					ring_d[i] = ring_q[(i + 1) % NumChannels];
				end
			end else begin
				cnt_d = cnt_inc[15:0];
			end
		end else if (in_range) begin
			ring_d[idx] = w_new;
		end

		result.pin_levels = 8'd0;
		if (cnt_d != 16'd0 && {4'd0, latched_d} >= cnt_d && 5'(slot_d) < 5'd8) begin
			result.pin_levels = 8'd1 << slot_d;
		end
		result.active_channel   = 3'(slot_d);
		result.command_ignored  = ignored;
		result.channel_width_us = in_range ? w_new : 12'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumChannels; i++) begin
				ring_q[i] <= 12'd0;
			end
			slot_q    <= '0;
			cnt_q     <= 16'd0;
			latched_q <= 12'd0;
		end else if (commit) begin
			ring_q    <= ring_d;
			slot_q    <= slot_d;
			cnt_q     <= cnt_d;
			latched_q <= latched_d;
		end
	end

endmodule

// ----- src/multiplexed_servo_pulse_sequencer.sv -----
// The single-pass core update sits between the input register and
// the result register: one item per cycle unless the output stalls.
// The input and result registers decouple the two stream sides.
// Reset: arst_n clears widths, slot state, valid flags and restores the
// configuration to min 544, max 2400 and slot length 2500.
module multiplexed_servo_pulse_sequencer #(
	parameter int NumChannels = msps_pkg::NUM_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[1:0], channel[4:2], amount_us[16:5], zero fill[23:17]
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pin_levels[7:0], active_channel[10:8], command_ignored[11],
	// channel_width_us[23:12]
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	msps_pkg::cfg_t    cfg;
	msps_pkg::item_t   item_s1;
	msps_pkg::result_t result;
	msps_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	msps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	msps_core #(
		.NumChannels (NumChannels)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.operation <= msps_pkg::op_t'(s_axis_tdata[1:0]);
			item_s1.channel   <= s_axis_tdata[4:2];
			item_s1.amount_us <= s_axis_tdata[16:5];
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {result_s2.channel_width_us, result_s2.command_ignored,
		result_s2.active_channel, result_s2.pin_levels};

endmodule

// ----- src/msps_checker.sv -----
// Port-level checker for the servo sequencer and its bind.
`include "multiplexed_servo_pulse_sequencer_defines.svh"

module msps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	`MSPS_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`MSPS_ASSERT_IMP(a_stall_only_backpressure, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
	`MSPS_ASSERT_IMP(a_one_pin_high, clk, arst_n, m_axis_tvalid, $onehot0(m_axis_tdata[7:0]))
	`MSPS_ASSERT_IMP(a_pin_is_active, clk, arst_n, m_axis_tvalid && m_axis_tdata[7:0] != 8'd0, m_axis_tdata[7:0] == (8'd1 << m_axis_tdata[10:8]))

endmodule

bind multiplexed_servo_pulse_sequencer msps_checker u_msps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb_multiplexed_servo_pulse_sequencer.sv -----
// Self-checking testbench for the multiplexed servo pulse sequencer.
module tb_multiplexed_servo_pulse_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import msps_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	multiplexed_servo_pulse_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the sequencer state and its configuration registers.
	logic [11:0] width_store [NUM_CHANNELS_DEF];
	logic [2:0]  slot_ch;
	logic [16:0] tick_cnt;
	logic [11:0] held_width;
	cfg_t        cfg_shadow;

	result_t     predicted_outputs [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_free = 0;
	int unsigned rdy_hold = 0;
	int unsigned rdy_free = 0;
	int unsigned rdy_roll;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rdy_hold > 0) begin
			rdy_hold--;
			m_axis_tready <= 1'b0;
		end else if (rdy_free > 0) begin
			rdy_free--;
			m_axis_tready <= 1'b1;
		end else begin
			rdy_roll = $urandom_range(0, 99);
			if (rdy_roll < 5) begin
				rdy_free = $urandom_range(30, 120);
				m_axis_tready <= 1'b1;
			end else if (rdy_roll < 65) begin
				m_axis_tready <= 1'b1;
			end else if (rdy_roll < 93) begin
				rdy_hold = $urandom_range(0, 2);
				m_axis_tready <= 1'b0;
			end else begin
				rdy_hold = $urandom_range(6, 30);
				m_axis_tready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_result
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pin_levels       = m_axis_tdata[7:0];
			got.active_channel   = m_axis_tdata[10:8];
			got.command_ignored  = m_axis_tdata[11];
			got.channel_width_us = m_axis_tdata[23:12];
			if (predicted_outputs.size() == 0) begin
				$error("result transfer with no prediction waiting: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = predicted_outputs.pop_front();
				if (got.pin_levels !== want.pin_levels) begin
					$error("pin_levels expected %0h got %0h", want.pin_levels, got.pin_levels);
					fail_count++;
				end
				if (got.active_channel !== want.active_channel) begin
					$error("active_channel expected %0d got %0d",
						want.active_channel, got.active_channel);
					fail_count++;
				end
				if (got.command_ignored !== want.command_ignored) begin
					$error("command_ignored expected %0d got %0d",
						want.command_ignored, got.command_ignored);
					fail_count++;
				end
				if (got.channel_width_us !== want.channel_width_us) begin
					$error("channel_width_us expected %0d got %0d",
						want.channel_width_us, got.channel_width_us);
					fail_count++;
				end
			end
		end
	end

	function automatic result_t step_sequencer(op_t op, logic [2:0] ch, logic [11:0] amt);
		result_t     r;
		logic [11:0] w;
		logic [12:0] sum;
		int          diff;
		r = '0;
		if (op == OP_TICK) begin
			if (tick_cnt == 0)
				held_width = width_store[ch == ch ? slot_ch : slot_ch];
			tick_cnt = tick_cnt + 17'd1;
			if (tick_cnt >= {1'b0, cfg_shadow.slot_length_us}) begin
				tick_cnt = '0;
				if (slot_ch == 3'(NUM_CHANNELS_DEF - 1))
					slot_ch = '0;
				else
					slot_ch = slot_ch + 3'd1;
			end
		end else begin
			w = width_store[ch];
			case (op)
				OP_SET: begin
					w = amt;
					if (w > cfg_shadow.max_pulse_us)
						w = cfg_shadow.max_pulse_us;
					if (w < cfg_shadow.min_pulse_us)
						w = cfg_shadow.min_pulse_us;
				end
				OP_INCREASE: begin
					sum = {1'b0, w} + {1'b0, amt};
					if (sum > {1'b0, cfg_shadow.max_pulse_us})
						r.command_ignored = 1'b1;
					else
						w = sum[11:0];
				end
				default: begin
					diff = int'(w) - int'(amt);
					if (diff < int'(cfg_shadow.min_pulse_us))
						r.command_ignored = 1'b1;
					else
						w = 12'(diff);
				end
			endcase
			width_store[ch] = w;
		end
		r.channel_width_us = width_store[ch];
		r.active_channel = slot_ch;
		if (tick_cnt != 0 && tick_cnt <= {5'd0, held_width})
			r.pin_levels = 8'd1 << slot_ch;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (send_free > 0) begin
			send_free--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			send_free = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_item(op_t op, logic [2:0] ch, logic [11:0] amt);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, amt, ch, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predicted_outputs.push_back(step_sequencer(op, ch, amt));
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_MIN_PULSE: cfg_shadow.min_pulse_us = data[11:0];
			CFG_MAX_PULSE: cfg_shadow.max_pulse_us = data[11:0];
			CFG_SLOT_LENGTH: cfg_shadow.slot_length_us = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(logic [11:0] lo, logic [11:0] hi, logic [15:0] slot);
		wait_idle();
		write_reg(CFG_MIN_PULSE, {4'd0, lo});
		write_reg(CFG_MAX_PULSE, {4'd0, hi});
		write_reg(CFG_SLOT_LENGTH, slot);
	endtask

	task automatic test_reset_values();
		send_item(OP_TICK, 3'd0, 12'd0);
		send_item(OP_INCREASE, 3'd3, 12'd0);
		send_item(OP_DECREASE, 3'd3, 12'd0);
		send_item(OP_SET, 3'd0, 12'd0);
		send_item(OP_SET, 3'd7, 12'hFFF);
		send_item(OP_INCREASE, 3'd7, 12'd1);
		send_item(OP_DECREASE, 3'd0, 12'd1);
		send_item(OP_INCREASE, 3'd0, 12'hFFF);
		send_item(OP_DECREASE, 3'd7, 12'hFFF);
	endtask

	task automatic test_limit_extremes();
		apply_settings(12'd0, 12'hFFF, 16'd0);
		send_item(OP_SET, 3'd1, 12'hFFF);
		send_item(OP_INCREASE, 3'd1, 12'd1);
		send_item(OP_DECREASE, 3'd1, 12'hFFF);
		send_item(OP_INCREASE, 3'd2, 12'hFFF);
		repeat (4) send_item(OP_TICK, 3'd2, 12'hFFF);
		apply_settings(12'hFFF, 12'd0, 16'hFFFF);
		send_item(OP_SET, 3'd5, 12'd0);
		send_item(OP_SET, 3'd6, 12'hFFF);
		repeat (3) send_item(OP_TICK, 3'd6, 12'd0);
	endtask

	task automatic run_random_phase(logic [11:0] lo, logic [11:0] hi, logic [15:0] slot,
			int unsigned count);
		int unsigned roll;
		int unsigned span;
		op_t         op;
		logic [11:0] amt;
		apply_settings(lo, hi, slot);
		span = ((hi > lo) ? hi : lo) * 2 + 8;
		if (span > 4095)
			span = 4095;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				op = OP_TICK;
			else if (roll < 70)
				op = OP_SET;
			else if (roll < 85)
				op = OP_INCREASE;
			else
				op = OP_DECREASE;
			if ($urandom_range(0, 3) == 0)
				amt = 12'($urandom_range(0, 4095));
			else
				amt = 12'($urandom_range(0, span));
			send_item(op, 3'($urandom_range(0, 7)), amt);
		end
	endtask

	task automatic test_random_settings();
		run_random_phase(12'd0, 12'd12, 16'd8, 170);
		run_random_phase(12'd2, 12'd30, 16'd20, 170);
		run_random_phase(12'd0, 12'hFFF, 16'd3, 170);
		run_random_phase(12'd5, 12'd5, 16'd2, 160);
		run_random_phase(12'd20, 12'd10, 16'd6, 160);
		run_random_phase(12'($urandom_range(0, 63)), 12'($urandom_range(0, 80)),
			16'($urandom_range(1, 40)), 170);
		run_random_phase(12'd1000, 12'd3000, 16'd2, 160);
		run_random_phase(12'd0, 12'd100, 16'd1, 150);
		run_random_phase(12'd0, 12'd100, 16'hFFFF, 80);
		run_random_phase(12'd0, 12'd9, 16'd12, 170);
		run_random_phase(MIN_PULSE_RST, MAX_PULSE_RST, SLOT_LENGTH_RST, 80);
	endtask

	initial begin
		for (int i = 0; i < NUM_CHANNELS_DEF; i++)
			width_store[i] = '0;
		slot_ch = '0;
		tick_cnt = '0;
		held_width = '0;
		cfg_shadow.min_pulse_us = MIN_PULSE_RST;
		cfg_shadow.max_pulse_us = MAX_PULSE_RST;
		cfg_shadow.slot_length_us = SLOT_LENGTH_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_limit_extremes();
		test_random_settings();
		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/msps_pkg.sv
src/msps_cfg_regs.sv
src/msps_core.sv
src/multiplexed_servo_pulse_sequencer.sv
src/msps_checker.sv
tb/sv/tb_multiplexed_servo_pulse_sequencer.sv
